// ===== hw/rtl/ppf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_pkg: shared types and constants of the pressure plausibility filter
// Holds the register indexes, reset values, verdict codes and the structs
// that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package ppf_pkg;

    localparam int unsigned ValueWidth = 16;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned IndexWidth = 3;

    localparam logic [ValueWidth-1:0] InvalidRaw = 16'hFFFF;
    localparam logic [CountWidth-1:0] CountMax   = 4'd15;

    // Register indexes of the configuration port.
    localparam logic [IndexWidth-1:0] CFG_MIN_LIMIT         = 3'd0;
    localparam logic [IndexWidth-1:0] CFG_MAX_LIMIT         = 3'd1;
    localparam logic [IndexWidth-1:0] CFG_JUMP_LIMIT        = 3'd2;
    localparam logic [IndexWidth-1:0] CFG_CONFIRM_TOLERANCE = 3'd3;
    localparam logic [IndexWidth-1:0] CFG_CONFIRM_COUNT     = 3'd4;

    // Values after reset, tenths of kPa where a pressure.
    localparam logic [ValueWidth-1:0] MinLimitReset         = 16'd300;
    localparam logic [ValueWidth-1:0] MaxLimitReset         = 16'd1200;
    localparam logic [ValueWidth-1:0] JumpLimitReset        = 16'd15;
    localparam logic [ValueWidth-1:0] ConfirmToleranceReset = 16'd3;
    localparam logic [CountWidth-1:0] ConfirmCountReset     = 4'd3;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED       = 3'd0,
        VERDICT_OVER_RANGE     = 3'd1,
        VERDICT_JUMP_REJECTED  = 3'd2,
        VERDICT_JUMP_CONFIRMED = 3'd3,
        VERDICT_READ_FAILED    = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [ValueWidth-1:0] min_limit;
        logic [ValueWidth-1:0] max_limit;
        logic [ValueWidth-1:0] jump_limit;
        logic [ValueWidth-1:0] confirm_tolerance;
        logic [CountWidth-1:0] confirm_count;
    } cfg_t;

    typedef struct packed {
        logic [ValueWidth-1:0] reading_value;
        logic                  reading_valid;
        verdict_t              verdict;
        logic [CountWidth-1:0] confirmations;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppf_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_cfg: configuration registers
// Five write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module ppf_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ppf_pkg::IndexWidth-1:0] cfg_index,
    input  wire logic [ppf_pkg::ValueWidth-1:0] cfg_wdata,
    output ppf_pkg::cfg_t                       cfg
);
    import ppf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_limit         <= MinLimitReset;
            cfg_reg.max_limit         <= MaxLimitReset;
            cfg_reg.jump_limit        <= JumpLimitReset;
            cfg_reg.confirm_tolerance <= ConfirmToleranceReset;
            cfg_reg.confirm_count     <= ConfirmCountReset;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_LIMIT:         cfg_reg.min_limit         <= cfg_wdata;
                CFG_MAX_LIMIT:         cfg_reg.max_limit         <= cfg_wdata;
                CFG_JUMP_LIMIT:        cfg_reg.jump_limit        <= cfg_wdata;
                CFG_CONFIRM_TOLERANCE: cfg_reg.confirm_tolerance <= cfg_wdata;
                CFG_CONFIRM_COUNT: begin
                    cfg_reg.confirm_count <= cfg_wdata[CountWidth-1:0];
                end
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ppf_judge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_judge: plausibility decision and filter state
// Classifies one reading against the limits and the last accepted value,
// tracks a pending jump and updates the state when the word moves on.
// ----------------------------------------------------------------------------
module ppf_judge (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic                           read_ok,
    input  wire logic [ppf_pkg::ValueWidth-1:0] raw_reading,
    input  ppf_pkg::cfg_t                       cfg,
    output ppf_pkg::result_t                    result
);
    import ppf_pkg::*;

    logic [ValueWidth-1:0] last_accepted_reg, last_accepted_next;
    logic                  have_accepted_reg, have_accepted_next;
    logic [ValueWidth-1:0] pending_value_reg, pending_value_next;
    logic [CountWidth-1:0] pending_count_reg, pending_count_next;

    logic [ValueWidth-1:0] diff_last;
    logic [ValueWidth-1:0] diff_pending;
    logic [CountWidth-1:0] need;
    logic [CountWidth-1:0] count_jump;

    assign diff_last = (raw_reading >= last_accepted_reg) ?
                       raw_reading - last_accepted_reg : last_accepted_reg - raw_reading;
    assign diff_pending = (raw_reading >= pending_value_reg) ?
                          raw_reading - pending_value_reg : pending_value_reg - raw_reading;
    // A confirm count of zero behaves as one.
    assign need = (cfg.confirm_count == '0) ? CountWidth'(1) : cfg.confirm_count;

    always_comb begin
        last_accepted_next = last_accepted_reg;
        have_accepted_next = have_accepted_reg;
        pending_value_next = pending_value_reg;
        pending_count_next = pending_count_reg;
        count_jump         = pending_count_reg;

        result.reading_value = raw_reading;
        result.reading_valid = 1'b0;
        result.verdict       = VERDICT_READ_FAILED;

        if (!read_ok || raw_reading == InvalidRaw) begin
            result.reading_value = '0;
        end else if (raw_reading < cfg.min_limit || raw_reading > cfg.max_limit) begin
            result.verdict = VERDICT_OVER_RANGE;
        end else if (!have_accepted_reg || diff_last <= cfg.jump_limit) begin
            last_accepted_next   = raw_reading;
            have_accepted_next   = 1'b1;
            pending_count_next   = '0;
            result.reading_valid = 1'b1;
            result.verdict       = VERDICT_ACCEPTED;
        end else begin
            // A reading close to the pending jump adds to its count, any
            // other jump starts a new pending run.
            if (pending_count_reg != '0 && diff_pending <= cfg.confirm_tolerance) begin
                if (pending_count_reg != CountMax) begin
                    count_jump = pending_count_reg + CountWidth'(1);
                end
            end else begin
                pending_value_next = raw_reading;
                count_jump         = CountWidth'(1);
            end
            if (count_jump >= need) begin
                last_accepted_next   = raw_reading;
                pending_count_next   = '0;
                result.reading_valid = 1'b1;
                result.verdict       = VERDICT_JUMP_CONFIRMED;
            end else begin
                pending_count_next = count_jump;
                result.verdict     = VERDICT_JUMP_REJECTED;
            end
        end
        result.confirmations = pending_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_accepted_reg <= '0;
            have_accepted_reg <= 1'b0;
            pending_value_reg <= '0;
            pending_count_reg <= '0;
        end else if (step) begin
            last_accepted_reg <= last_accepted_next;
            have_accepted_reg <= have_accepted_next;
            pending_value_reg <= pending_value_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pressure_plausibility_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_plausibility_filter_core: spike rejection filter with confirmation
// Checks pressure readings for read failures, range and sudden jumps, and
// accepts a jump only once enough consistent readings have confirmed it.
// ----------------------------------------------------------------------------
//   Channel  Direction  Word
//   s_       in         tdata: raw_reading; tuser: read_ok
//   m_       out        tdata: reading_value, confirmations; tuser: reading_valid, verdict
//   cfg_     in         register index and write data, no read-back
//
// A word is held in the input register, then judged and moved to the result
// register; one word per cycle while m_ is not stalled.
// The filter state is updated at the edge where a word enters the result
// register. A stall on m_ holds the result register and the input register,
// and s_tready falls only when both are full. Reset is synchronous and
// clears the valid flags and filter state and restores the configuration values.
// ----------------------------------------------------------------------------
module pressure_plausibility_filter_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input channel
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [ppf_pkg::ValueWidth-1:0] s_tdata,  // [15:0] raw_reading
    input  wire logic                           s_tuser,  // [0] read_ok
    // Result channel
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [23:0]                    m_tdata,  // [15:0] reading_value,
                                                          // [19:16] confirmations, zeros
    output      logic [3:0]                     m_tuser,  // [0] reading_valid, [3:1] verdict
    // Configuration port
    input  wire logic                           cfg_we,
    input  wire logic [ppf_pkg::IndexWidth-1:0] cfg_index,
    input  wire logic [ppf_pkg::ValueWidth-1:0] cfg_wdata
);
    import ppf_pkg::*;

    cfg_t                  cfg;
    result_t               result;

    logic                  in_valid_reg;
    logic                  in_ok_reg;
    logic [ValueWidth-1:0] in_raw_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ppf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ppf_judge u_judge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .read_ok     (in_ok_reg),
        .raw_reading (in_raw_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ok_reg  <= s_tuser;
            in_raw_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.confirmations, out_reg.reading_value};
    assign m_tuser  = {out_reg.verdict, out_reg.reading_valid};

endmodule
`default_nettype wire

// ===== sim/ppf_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppf_result_checker: scoreboard of the pressure plausibility filter
// Watches the configuration port and both stream channels, works out the
// verdict of every accepted reading with its own copy of the filter state
// and compares each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ppf_result_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [ppf_pkg::ValueWidth-1:0] s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [23:0]                    m_tdata,
    input  wire logic [3:0]                     m_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [ppf_pkg::IndexWidth-1:0] cfg_index,
    input  wire logic [ppf_pkg::ValueWidth-1:0] cfg_wdata,
    output int unsigned                         fail_count,
    output int unsigned                         outstanding
);
    import ppf_pkg::*;

    cfg_t                  limits;
    logic [ValueWidth-1:0] held_value;
    logic                  held_valid;
    logic [ValueWidth-1:0] spike_value;
    logic [CountWidth-1:0] spike_count;

    result_t     predicted_results[$];
    int unsigned words_seen;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        words_seen  = 0;
    end

    function automatic logic [ValueWidth-1:0] distance(input logic [ValueWidth-1:0] a,
                                                       input logic [ValueWidth-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        // Keep the log readable if the block is badly broken.
        if (fail_count < 40) begin
            $display("MISMATCH at result word %0d, %s: expected %0d, got %0d",
                     words_seen, what, want, got);
        end
        fail_count++;
    endtask

    // Judges one reading and moves the filter state on, as the block does.
    task automatic judge_reading(input logic ok, input logic [ValueWidth-1:0] raw,
                                 output result_t res);
        logic [CountWidth-1:0] needed;
        needed = (limits.confirm_count == '0) ? 4'd1 : limits.confirm_count;
        res.reading_value = raw;
        res.reading_valid = 1'b0;
        res.verdict       = VERDICT_ACCEPTED;
        if (!ok || raw == InvalidRaw) begin
            res.reading_value = '0;
            res.verdict       = VERDICT_READ_FAILED;
        end else if (raw < limits.min_limit || raw > limits.max_limit) begin
            res.verdict = VERDICT_OVER_RANGE;
        end else if (!held_valid || distance(raw, held_value) <= limits.jump_limit) begin
            held_value        = raw;
            held_valid        = 1'b1;
            spike_count       = '0;
            res.reading_valid = 1'b1;
        end else begin
            if (spike_count != '0 &&
                distance(raw, spike_value) <= limits.confirm_tolerance) begin
                if (spike_count != CountMax) begin
                    spike_count = spike_count + 4'd1;
                end
            end else begin
                spike_value = raw;
                spike_count = 4'd1;
            end
            if (spike_count >= needed) begin
                held_value        = raw;
                spike_count       = '0;
                res.reading_valid = 1'b1;
                res.verdict       = VERDICT_JUMP_CONFIRMED;
            end else begin
                res.verdict = VERDICT_JUMP_REJECTED;
            end
        end
        res.confirmations = spike_count;
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        result_t fresh;
        if (!aresetn) begin
            limits.min_limit         = MinLimitReset;
            limits.max_limit         = MaxLimitReset;
            limits.jump_limit        = JumpLimitReset;
            limits.confirm_tolerance = ConfirmToleranceReset;
            limits.confirm_count     = ConfirmCountReset;
            held_value               = '0;
            held_valid               = 1'b0;
            spike_value              = '0;
            spike_count              = '0;
            predicted_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_LIMIT:         limits.min_limit         = cfg_wdata;
                    CFG_MAX_LIMIT:         limits.max_limit         = cfg_wdata;
                    CFG_JUMP_LIMIT:        limits.jump_limit        = cfg_wdata;
                    CFG_CONFIRM_TOLERANCE: limits.confirm_tolerance = cfg_wdata;
                    CFG_CONFIRM_COUNT:     limits.confirm_count     = cfg_wdata[CountWidth-1:0];
                    default: ;
                endcase
            end
            // Results are checked before the new reading is predicted, so a
            // word leaving and one entering on the same edge do not mix.
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    flag_mismatch("word with no reading waiting", 0, 32'(m_tdata));
                end else begin
                    want = predicted_results.pop_front();
                    if (m_tdata[15:0] !== want.reading_value)
                        flag_mismatch("reading_value", 32'(want.reading_value),
                                      32'(m_tdata[15:0]));
                    if (m_tdata[19:16] !== want.confirmations)
                        flag_mismatch("confirmations", 32'(want.confirmations),
                                      32'(m_tdata[19:16]));
                    if (m_tdata[23:20] !== 4'd0)
                        flag_mismatch("tdata padding", 0, 32'(m_tdata[23:20]));
                    if (m_tuser[0] !== want.reading_valid)
                        flag_mismatch("reading_valid", 32'(want.reading_valid),
                                      32'(m_tuser[0]));
                    if (m_tuser[3:1] !== want.verdict)
                        flag_mismatch("verdict", 32'(want.verdict), 32'(m_tuser[3:1]));
                end
                words_seen++;
            end
            if (s_tvalid && s_tready) begin
                judge_reading(s_tuser, s_tdata, fresh);
                predicted_results.push_back(fresh);
            end
        end
        outstanding = predicted_results.size();
    end

endmodule

// ===== sim/tb_pressure_plausibility_filter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pressure_plausibility_filter_core: regression of the plausibility filter
// Drives directed readings and then phases of random reading sequences under
// changing limits, with bursty input, a stalling receiver and one long
// hold-off. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_pressure_plausibility_filter_core;
    import ppf_pkg::*;

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned PhaseWords  = 104;
    localparam int unsigned PhaseCount  = 12;
    localparam int unsigned HoldCycles  = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [ValueWidth-1:0] s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic [3:0]            m_tuser;
    logic                  cfg_we;
    logic [IndexWidth-1:0] cfg_index;
    logic [ValueWidth-1:0] cfg_wdata;

    int unsigned fail_count;
    int unsigned outstanding;

    // Stimulus view of the limits, used only to shape the readings.
    int unsigned set_lo, set_hi, set_jump, set_tol, set_count;
    int          level;
    int unsigned confirm_left;
    int unsigned burst_left;
    logic        steady;
    int unsigned hold_seq;
    int unsigned hold_served;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pressure_plausibility_filter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ppf_result_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Offers one word and waits for the edge that takes it.
    task automatic offer_word(input logic ok, input logic [ValueWidth-1:0] raw);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= ok;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= 16'($urandom);
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic send_word(input logic ok, input logic [ValueWidth-1:0] raw);
        if (burst_left == 0) begin
            if (!steady && $urandom_range(3, 0) != 0)
                idle_gap($urandom_range(12, 1));
            burst_left = $urandom_range(30, 1);
        end
        burst_left--;
        offer_word(ok, raw);
    endtask

    // The sender stops and waits until every predicted word has come back.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IndexWidth-1:0] idx,
                             input logic [ValueWidth-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic apply_settings(input int unsigned lo, input int unsigned hi,
                                  input int unsigned jump, input int unsigned tol,
                                  input int unsigned count);
        wait_for_results();
        write_reg(CFG_MIN_LIMIT, lo[15:0]);
        write_reg(CFG_MAX_LIMIT, hi[15:0]);
        write_reg(CFG_JUMP_LIMIT, jump[15:0]);
        write_reg(CFG_CONFIRM_TOLERANCE, tol[15:0]);
        write_reg(CFG_CONFIRM_COUNT, {12'd0, count[3:0]});
        @(negedge aclk);
        cfg_we    <= 1'b0;
        set_lo    = lo;
        set_hi    = hi;
        set_jump  = jump;
        set_tol   = tol;
        set_count = count;
    endtask

    function automatic logic [ValueWidth-1:0] in_range_value();
        if (set_lo <= set_hi)
            return 16'($urandom_range(set_hi, set_lo));
        return 16'($urandom);
    endfunction

    // A value at most spread away from base, or exactly one beyond it.
    function automatic logic [ValueWidth-1:0] near_value(input int base,
                                                         input int unsigned spread,
                                                         input logic beyond);
        int offset;
        int value;
        offset = beyond ? int'(spread) + 1 : int'($urandom_range(spread, 0));
        value  = $urandom_range(1, 0) ? base + offset : base - offset;
        if (value < 0)
            value = 0;
        if (value > 65534)
            value = 65534;
        return value[15:0];
    endfunction

    // Mostly plausible sequences: a settled level with small noise, and jumps
    // to a new level followed by readings that may confirm it. The rest is
    // failed reads, out-of-range values and raw noise.
    task automatic random_reading(output logic ok, output logic [ValueWidth-1:0] raw);
        int unsigned kind;
        kind = $urandom_range(99, 0);
        ok   = 1'b1;
        if (kind < 8) begin
            ok  = 1'b0;
            raw = 16'($urandom);
        end else if (kind < 11) begin
            raw = InvalidRaw;
        end else if (kind < 16) begin
            if (set_lo > 0 && (set_hi >= 65534 || $urandom_range(1, 0) == 1))
                raw = 16'($urandom_range(set_lo - 1, 0));
            else if (set_hi < 65534)
                raw = 16'($urandom_range(65534, set_hi + 1));
            else
                raw = 16'($urandom);
        end else if (kind < 20) begin
            raw = 16'($urandom);
        end else if (kind < 30) begin
            level        = int'(in_range_value());
            confirm_left = $urandom_range(set_count + 2, 0);
            raw          = level[15:0];
        end else if (confirm_left > 0) begin
            confirm_left--;
            raw = near_value(level, set_tol, $urandom_range(9, 0) == 0);
        end else begin
            raw   = near_value(level, set_jump, $urandom_range(9, 0) == 0);
            level = int'(raw);
        end
    endtask

    // Receiver: changing stall patterns, and a long hold-off on request.
    initial begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seq != hold_served) begin
                m_tready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge aclk);
                hold_served = hold_seq;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(3, 0);
                    mode_left = $urandom_range(80, 10);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(1, 0) == 1;
                    2:       m_tready <= $urandom_range(3, 0) == 0;
                    default: m_tready <= (tick % 4) != 0;
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TIMEOUT after %0d cycles with %0d words outstanding", cycles, outstanding);
        $display("pressure_plausibility_filter_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic                  ok;
        logic [ValueWidth-1:0] raw;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MIN_LIMIT;
        cfg_wdata    = '0;
        set_lo       = 32'(MinLimitReset);
        set_hi       = 32'(MaxLimitReset);
        set_jump     = 32'(JumpLimitReset);
        set_tol      = 32'(ConfirmToleranceReset);
        set_count    = 32'(ConfirmCountReset);
        level        = 600;
        confirm_left = 0;
        burst_left   = 0;
        steady       = 1'b0;
        hold_seq     = 0;
        hold_served  = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Settings after reset: failed reads, range edges, first acceptance,
        // a jump confirmed by close readings, and a restarted pending value.
        send_word(1'b0, 16'd500);
        send_word(1'b1, InvalidRaw);
        send_word(1'b0, InvalidRaw);
        send_word(1'b1, 16'd0);
        send_word(1'b1, 16'd299);
        send_word(1'b1, 16'd1201);
        send_word(1'b1, 16'd300);
        send_word(1'b1, 16'd315);
        send_word(1'b1, 16'd331);
        send_word(1'b1, 16'd334);
        send_word(1'b1, InvalidRaw);
        send_word(1'b1, 16'd5000);
        send_word(1'b1, 16'd331);
        send_word(1'b1, 16'd1200);
        send_word(1'b1, 16'd700);
        send_word(1'b1, 16'd316);

        // A confirm count of zero takes any jump at once; full-scale values.
        apply_settings(0, 65535, 0, 0, 0);
        send_word(1'b1, 16'd0);
        send_word(1'b1, 16'd65534);
        send_word(1'b1, 16'd65534);
        send_word(1'b1, InvalidRaw);

        // Crossed limits put every good reading out of range.
        apply_settings(65535, 0, 15, 3, 3);
        send_word(1'b1, 16'd1000);
        send_word(1'b1, 16'd0);

        for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                0:       apply_settings(0, 65535, 65535, 65535, 15);
                1:       apply_settings(0, 65535, 0, 0, 1);
                2:       apply_settings(1000, 1000, 0, 0, 2);
                3:       apply_settings(40000, 100, 20, 5, 4);
                4:       apply_settings(0, 65535, 0, 65535, 15);
                default: begin
                    set_lo = $urandom_range(30000, 0);
                    apply_settings(set_lo, set_lo + $urandom_range(35000, 0),
                                   $urandom_range(60, 0), $urandom_range(10, 0),
                                   $urandom_range(15, 0));
                end
            endcase
            steady = (phase % 3) == 1;
            level  = int'(in_range_value());
            for (int unsigned n = 0; n < PhaseWords; n++) begin
                // Halfway through one phase the receiver holds off while the
                // sender keeps offering, so the block fills and stalls.
                if (phase == 6 && n == PhaseWords / 2) begin
                    hold_seq++;
                    steady = 1'b1;
                end
                random_reading(ok, raw);
                send_word(ok, raw);
            end
        end

        wait_for_results();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("pressure_plausibility_filter_core regression: pass");
        end else begin
            $display("pressure_plausibility_filter_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== pressure_plausibility_filter_core.f =====
hw/rtl/ppf_pkg.sv
hw/rtl/ppf_cfg.sv
hw/rtl/ppf_judge.sv
hw/rtl/pressure_plausibility_filter_core.sv
sim/ppf_result_checker.sv
sim/tb_pressure_plausibility_filter_core.sv
